// ----- hdl/grid_raycast_column_renderer_macros.svh -----
// assertion macros shared by the checker files of the column renderer
// needs a clk and an active-low arst_n in the scope where a macro is used
`ifndef GRID_RAYCAST_COLUMN_RENDERER_MACROS_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_MACROS_SVH

// antecedent holds, consequent in the same cycle
`define GRC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("column renderer check failed");

// antecedent holds, consequent in the next cycle
`define GRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("column renderer check failed");

`endif

// ----- hdl/grc_pkg.sv -----
// shared types, constants and constant tables of the column renderer
// no dependencies; used by every rtl module and the checker
package grc_pkg;

	localparam int MAP_SIZE    = 16;
	localparam int SCREEN_ROWS = 40;
	localparam int SCREEN_COLS = 120;
	localparam int MAX_STEPS   = 160;

	localparam int MAP_REGS = 4;
	localparam int REG_W    = 64;
	localparam int PADDR_W  = $clog2(MAP_REGS * 8);

	localparam int ANG_W  = 10;
	localparam int N_W    = $clog2(MAX_STEPS + 1);
	localparam int ROW_W  = 6;
	localparam int COL_W  = 7;
	localparam int CELL_W = $clog2(MAP_SIZE) + 2;
	localparam int REM_W  = 26;
	localparam int SUM_W  = REM_W + 2;
	localparam int TRIG_W = 16;
	localparam int DELTA_W = TRIG_W + 8;
	localparam int CEIL_W = $clog2(SCREEN_ROWS / 2 + 1) + 1;
	localparam int YC_W   = CEIL_W + 2;
	localparam int Y10_W  = ROW_W + 4;

	// position scale: one cell is 2^8 * 2^14 * 10
	localparam logic [SUM_W-1:0] CELL_SPAN = SUM_W'(41943040);
	localparam logic [17:0] POS_SCALE = 18'd163840;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_BAR   = 8'h49;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef logic [MAP_REGS-1:0][REG_W-1:0] map_regs_t;
	typedef logic [256:0][14:0] sin_tab_t;
	typedef logic [127:0][ANG_W-1:0] col_tab_t;
	typedef logic [MAX_STEPS:0][CEIL_W-1:0] ceil_tab_t;

	typedef struct packed {
		logic [11:0] viewer_x;
		logic [11:0] viewer_y;
		logic [9:0]  view_angle;
		logic [6:0]  column_index;
	} ray_t;

	typedef struct packed {
		logic [6:0] out_column;
		logic [5:0] out_row;
		logic [7:0] char_code;
		logic [7:0] wall_steps;
		logic       last_row;
	} pix_t;

	typedef struct packed {
		logic load;
		logic trig_x;
		logic trig_y;
		logic step;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic stop;
		logic row_last;
	} status_t;

	// taylor series of sine over one quarter, q1.14
	function automatic logic [14:0] quarter_sine(input logic [8:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x = ({55'd0, r} * PI_Q30) >> 9;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		// odd powers alternate in sign, each term truncated before the next
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum + 64'sd32768) >>> 16;
		if (sum > 64'sd16384) begin
			sum = 64'sd16384;
		end
		return 15'(sum);
	endfunction

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t t;
		for (int i = 0; i <= 256; i++) begin
			t[i] = quarter_sine(9'(i));
		end
		return t;
	endfunction

	// angle offset of each screen column inside the field of view
	function automatic col_tab_t build_col_tab();
		col_tab_t t;
		for (int c = 0; c < 128; c++) begin
			t[c] = ANG_W'((c * 128) / SCREEN_COLS);
		end
		return t;
	endfunction

	// ceiling row per step count, truncated toward zero and clamped
	function automatic ceil_tab_t build_ceil_tab();
		ceil_tab_t t;
		int num;
		int den;
		int mag;
		int q;
		int v;
		for (int n = 0; n <= MAX_STEPS; n++) begin
			v = 0;
			if (n != 0) begin
				num = SCREEN_ROWS * (3 * n - 40);
				den = 6 * n;
				mag = (num < 0) ? -num : num;
				q = 0;
				while (mag >= den) begin
					mag = mag - den;
					q++;
				end
				v = (num < 0) ? -q : q;
			end
			if (v < -1) begin
				v = -1;
			end
			if (v > SCREEN_ROWS / 2) begin
				v = SCREEN_ROWS / 2;
			end
			t[n] = CEIL_W'(v);
		end
		return t;
	endfunction

	localparam sin_tab_t  SIN_TAB  = build_sin_tab();
	localparam col_tab_t  COL_TAB  = build_col_tab();
	localparam ceil_tab_t CEIL_TAB = build_ceil_tab();

endpackage

// ----- hdl/grc_regs.sv -----
// apb register file holding the 16x16 wall bitmap
// depends on grc_pkg
module grc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [grc_pkg::PADDR_W-1:0]   paddr,
	input  logic [grc_pkg::REG_W-1:0]     pwdata,
	output logic [grc_pkg::REG_W-1:0]     prdata,
	output logic                          pready,
	output grc_pkg::map_regs_t            map
);
	import grc_pkg::*;

	localparam int IDX_W = $clog2(MAP_REGS);

	map_regs_t map_q;
	logic [IDX_W-1:0] idx;

	assign idx = paddr[PADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (psel && penable && pwrite) begin
			map_q[idx] <= pwdata;
		end
	end

	assign prdata = map_q[idx];
	assign pready = 1'b1;
	assign map = map_q;

endmodule

// ----- hdl/grc_ctrl.sv -----
// sequencer for one column: angle, trig lookups, march, shade, row output
// depends on grc_pkg
module grc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ray_valid,
	output logic               ray_ready,
	output logic               pix_valid,
	input  logic               pix_ready,
	output grc_pkg::cmd_t      cmd,
	input  grc_pkg::status_t   status
);
	import grc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_TRIGX = 6'b000010,
		S_TRIGY = 6'b000100,
		S_MARCH = 6'b001000,
		S_SHADE = 6'b010000,
		S_EMIT  = 6'b100000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic pix_valid_q;
	logic slot_free;

	assign slot_free = !pix_valid_q || pix_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (ray_valid) begin
					cmd.load = 1'b1;
					state_d = S_TRIGX;
				end
			end
			S_TRIGX: begin
				cmd.trig_x = 1'b1;
				state_d = S_TRIGY;
			end
			S_TRIGY: begin
				cmd.trig_y = 1'b1;
				state_d = S_MARCH;
			end
			S_MARCH: begin
				cmd.step = 1'b1;
				if (status.stop) begin
					state_d = S_SHADE;
				end
			end
			S_SHADE: begin
				cmd.finish = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (status.row_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	assign ray_ready = (state_q == S_IDLE);
	assign pix_valid = pix_valid_q;

endmodule

// ----- hdl/grc_datapath.sv -----
// ray datapath: trig lookup, per-axis cell/remainder stepping, wall test,
// ceiling and shade, character selection and the output register
// depends on grc_pkg
module grc_datapath (
	input  logic               clk,
	input  grc_pkg::ray_t      ray,
	input  grc_pkg::map_regs_t map,
	input  grc_pkg::cmd_t      cmd,
	output grc_pkg::status_t   status,
	output grc_pkg::pix_t      pix
);
	import grc_pkg::*;

	typedef struct packed {
		logic signed [CELL_W-1:0] grid;
		logic [REM_W-1:0]         rem;
	} axis_t;

	localparam logic [Y10_W-1:0] FLOOR_DOT = Y10_W'(6 * SCREEN_ROWS);
	localparam logic [Y10_W-1:0] FLOOR_BAR = Y10_W'(8 * SCREEN_ROWS);

	// one tenth-cell step: the cell moves by at most one per step
	function automatic axis_t axis_step(input axis_t a, input logic signed [DELTA_W-1:0] d);
		axis_t r;
		logic signed [SUM_W-1:0] s;
		s = $signed({2'b00, a.rem}) + SUM_W'(d);
		r.grid = a.grid;
		if (s >= $signed(CELL_SPAN)) begin
			r.grid = a.grid + CELL_W'(1);
			r.rem = REM_W'(s - $signed(CELL_SPAN));
		end else if (s < 0) begin
			r.grid = a.grid - CELL_W'(1);
			r.rem = REM_W'(s + $signed(CELL_SPAN));
		end else begin
			r.rem = REM_W'(s);
		end
		return r;
	endfunction

	logic [11:0] vx_q, vy_q;
	logic [COL_W-1:0] col_q;
	logic [ANG_W-1:0] ang_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	axis_t ax_q, ay_q, ax_d, ay_d;
	logic [N_W-1:0] n_q, n_next;
	logic signed [CEIL_W-1:0] ceil_q;
	logic [7:0] shade_q;
	logic [ROW_W-1:0] y_q;
	pix_t pix_q;

	logic [ANG_W-1:0] sel_ang;
	logic [8:0] qidx;
	logic [14:0] qval;
	logic signed [TRIG_W-1:0] trig;
	logic out_x, out_y, out_map, wall;
	logic [MAP_REGS*REG_W-1:0] bitmap;
	logic [N_W+2:0] n8, n6, n4, n2;
	logic signed [YC_W-1:0] ys, cs, fs;
	logic [Y10_W-1:0] y10;
	logic [7:0] ch;

	// sine by quarter symmetry, cosine as sine a quarter turn on
	assign sel_ang = cmd.trig_y ? ang_q + ANG_W'(256) : ang_q;
	assign qidx = sel_ang[8] ? 9'd256 - {1'b0, sel_ang[7:0]} : {1'b0, sel_ang[7:0]};
	assign qval = SIN_TAB[qidx];
	assign trig = sel_ang[9] ? -$signed({1'b0, qval}) : $signed({1'b0, qval});

	assign ax_d = axis_step(ax_q, dx_q);
	assign ay_d = axis_step(ay_q, dy_q);
	assign n_next = n_q + N_W'(1);

	assign out_x = ax_d.grid[CELL_W-1] || (ax_d.grid[CELL_W-2:0] >= (CELL_W-1)'(MAP_SIZE));
	assign out_y = ay_d.grid[CELL_W-1] || (ay_d.grid[CELL_W-2:0] >= (CELL_W-1)'(MAP_SIZE));
	assign out_map = out_x || out_y;
	assign bitmap = map;
	assign wall = !out_map && (ax_d.grid[CELL_W-2:4] == '0) && (ay_d.grid[CELL_W-2:4] == '0)
		&& bitmap[{ay_d.grid[3:0], ax_d.grid[3:0]}];

	assign status.stop = out_map || wall || (n_next == N_W'(MAX_STEPS));
	assign status.row_last = (y_q == ROW_W'(SCREEN_ROWS - 1));

	assign n8 = {n_q, 3'b000};
	assign n6 = {1'b0, n_q, 2'b00} + {2'b00, n_q, 1'b0};
	assign n4 = {1'b0, n_q, 2'b00};
	assign n2 = {2'b00, n_q, 1'b0};

	assign ys = $signed(YC_W'(y_q));
	assign cs = YC_W'(ceil_q);
	assign fs = $signed(YC_W'(SCREEN_ROWS)) - cs;
	assign y10 = Y10_W'(y_q) * Y10_W'(10);

	always_comb begin
		if (ys < cs) begin
			ch = CH_SPACE;
		end else if (ys > cs && ys < fs) begin
			ch = shade_q;
		end else if (!col_q[0]) begin
			ch = CH_SPACE;
		end else if (y10 > FLOOR_BAR) begin
			ch = CH_UNDER;
		end else if (y10 > FLOOR_DOT) begin
			ch = CH_DOT;
		end else begin
			ch = CH_SPACE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vx_q <= ray.viewer_x;
			vy_q <= ray.viewer_y;
			col_q <= ray.column_index;
			ang_q <= ray.view_angle + ANG_W'(1024 - 64) + COL_TAB[ray.column_index];
		end
		if (cmd.trig_x) begin
			dx_q <= DELTA_W'(trig) <<< 8;
		end
		if (cmd.trig_y) begin
			dy_q <= DELTA_W'(trig) <<< 8;
			ax_q.grid <= CELL_W'(vx_q[11:8]);
			ax_q.rem <= REM_W'(vx_q[7:0]) * REM_W'(POS_SCALE);
			ay_q.grid <= CELL_W'(vy_q[11:8]);
			ay_q.rem <= REM_W'(vy_q[7:0]) * REM_W'(POS_SCALE);
			n_q <= '0;
		end
		if (cmd.step) begin
			ax_q <= ax_d;
			ay_q <= ay_d;
			n_q <= out_map ? N_W'(MAX_STEPS) : n_next;
		end
		if (cmd.finish) begin
			ceil_q <= $signed(CEIL_TAB[n_q]);
			y_q <= '0;
			if (n8 <= (N_W+3)'(MAX_STEPS)) begin
				shade_q <= CH_HASH;
			end else if (n6 < (N_W+3)'(MAX_STEPS)) begin
				shade_q <= CH_BAR;
			end else if (n4 < (N_W+3)'(MAX_STEPS)) begin
				shade_q <= CH_EQ;
			end else if (n2 < (N_W+3)'(MAX_STEPS)) begin
				shade_q <= CH_QUOTE;
			end else if (n_q < N_W'(MAX_STEPS)) begin
				shade_q <= CH_DOT;
			end else begin
				shade_q <= CH_SPACE;
			end
		end
		if (cmd.emit) begin
			pix_q.out_column <= col_q;
			pix_q.out_row <= y_q;
			pix_q.char_code <= ch;
			pix_q.wall_steps <= 8'(n_q);
			pix_q.last_row <= status.row_last;
			y_q <= y_q + ROW_W'(1);
		end
	end

	assign pix = pix_q;

endmodule

// ----- hdl/grid_raycast_column_renderer.sv -----
// top level of the grid raycast column renderer
// depends on grc_pkg, grc_regs, grc_ctrl, grc_datapath
//
// Casts one ray per transfer on the ray channel and returns the 40
// characters of that screen column, top row first, on the pix channel.
// The wall bitmap (16x16, one bit per cell) is written over the apb port
// as four 64-bit registers at byte addresses 0, 8, 16 and 24; write it
// only while no column is in flight. Per column the block latches the
// transfer, looks up sine and cosine, marches one tenth-cell step per
// cycle (1 to 160 steps, set by the distance to the first wall or the
// map edge), computes ceiling and shade, and then sends one character
// per cycle while the sink keeps pix_ready high.
// The next ray is taken as soon as the last character sits in the output
// register, before that character is taken by the sink.
module grid_raycast_column_renderer (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [grc_pkg::PADDR_W-1:0]   paddr,
	input  logic [grc_pkg::REG_W-1:0]     pwdata,
	output logic [grc_pkg::REG_W-1:0]     prdata,
	output logic                          pready,
	// ray requests
	input  logic                          ray_valid,
	output logic                          ray_ready,
	input  grc_pkg::ray_t                 ray,
	// character results
	output logic                          pix_valid,
	input  logic                          pix_ready,
	output grc_pkg::pix_t                 pix
);
	import grc_pkg::*;

	map_regs_t map;
	cmd_t cmd;
	status_t status;

	// wall bitmap registers
	grc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.map     (map)
	);

	// sequencer: owns the handshakes, issues at most one command per cycle
	grc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray_valid (ray_valid),
		.ray_ready (ray_ready),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// march, shading and character output register
	grc_datapath u_dp (
		.clk    (clk),
		.ray    (ray),
		.map    (map),
		.cmd    (cmd),
		.status (status),
		.pix    (pix)
	);

endmodule

// ----- hdl/grc_checker.sv -----
// port-level checks of the column renderer, bound to the top level
// depends on grc_pkg and grid_raycast_column_renderer_macros.svh
`include "grid_raycast_column_renderer_macros.svh"

module grc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          ray_valid,
	input logic          ray_ready,
	input grc_pkg::ray_t ray,
	input logic          pix_valid,
	input logic          pix_ready,
	input grc_pkg::pix_t pix
);
	import grc_pkg::*;

	// a stalled character holds its value
	`GRC_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix))

	// a taken ray is never followed by another in the next cycle
	`GRC_ASSERT_NEXT(a_one_ray, ray_valid && ray_ready, !ray_ready)

	// rows of a column come without gaps
	`GRC_ASSERT_NEXT(a_row_follow, pix_valid && pix_ready && !pix.last_row,
		pix_valid && (pix.out_row == 6'($past(pix.out_row) + 6'd1))
		&& (pix.out_column == $past(pix.out_column)))

	// last row flag only on the bottom row
	`GRC_ASSERT_SAME(a_last_row, pix_valid,
		pix.last_row == (pix.out_row == 6'(SCREEN_ROWS - 1)))

endmodule

bind grid_raycast_column_renderer grc_checker u_grc_checker (.*);

// ----- tb/grid_raycast_column_renderer_tb.sv -----
// self-checking testbench for the grid raycast column renderer
// depends on grc_pkg for the ray and pix transfer types and the apb widths
// predicts all 40 characters of each column and checks them in order
module grid_raycast_column_renderer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// wall bitmap registers, byte address 8 * index
	typedef enum int {
		MAP_ROWS_0_3   = 0,
		MAP_ROWS_4_7   = 1,
		MAP_ROWS_8_11  = 2,
		MAP_ROWS_12_15 = 3
	} map_reg_e;

	localparam int AW    = grc_pkg::PADDR_W;
	localparam int DW    = grc_pkg::REG_W;
	localparam int ROWS  = 40;
	localparam int COLS  = 120;
	localparam int STEPS = 160;
	localparam int GRID  = 16;

	// fixed-point scales: a position unit is 2^-8 cell, a ray step 0.1 cell
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint POS_UNITS  = 163840;
	localparam longint CELL_UNITS = 41943040;

	localparam logic [7:0] GLYPH_BLANK  = 8'h20;
	localparam logic [7:0] GLYPH_HASH   = 8'h23;
	localparam logic [7:0] GLYPH_BAR    = 8'h49;
	localparam logic [7:0] GLYPH_EQUALS = 8'h3D;
	localparam logic [7:0] GLYPH_TICK   = 8'h27;
	localparam logic [7:0] GLYPH_DOT    = 8'h2E;
	localparam logic [7:0] GLYPH_UNDER  = 8'h5F;

	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 250;
	localparam int HOLD_CYCLES   = 600;
	localparam int SHOWN_ERRORS  = 40;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AW-1:0] paddr;
	logic [DW-1:0] pwdata;
	logic [DW-1:0] prdata;
	logic pready;
	logic ray_valid;
	logic ray_ready;
	grc_pkg::ray_t ray;
	logic pix_valid;
	logic pix_ready;
	grc_pkg::pix_t pix;

	// testbench copy of the wall bitmap and the quarter-wave sine rom
	logic [63:0] wall_map [4];
	int sine_rom [257];

	// characters still owed by the block, oldest first
	grc_pkg::pix_t pending_pix [$];

	int errors;
	int stall_count;
	bit feed_idle;
	bit sink_idle;
	int sink_hold_req;

	grid_raycast_column_renderer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.ray_valid (ray_valid),
		.ray_ready (ray_ready),
		.ray       (ray),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// q1.14 sine over one quarter: taylor series to x^13 in q30, truncating
	// at each term, then rounded half up to q14 and capped at one
	function automatic int taylor_quarter(input int r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint acc;
		x = longint'(r) * PI_Q30 / 512;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			term = (term * x2) >> 30;
			term = term / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		acc = (acc + 32768) >>> 16;
		if (acc > 16384) begin
			acc = 16384;
		end
		return int'(acc);
	endfunction

	// full-turn sine from the quarter rom; odd quarters mirror, upper half negates
	function automatic int ray_sine(input int a);
		int r;
		int v;
		r = a % 256;
		v = ((a / 256) % 2 == 1) ? sine_rom[256 - r] : sine_rom[r];
		return ((a / 256) >= 2) ? -v : v;
	endfunction

	// map cell (floor) of one coordinate after n tenth-cell steps, -1 if negative
	function automatic longint grid_cell(input int pos, input int trig, input int n);
		longint p;
		p = longint'(pos) * POS_UNITS + longint'(trig) * n * 256;
		if (p < 0) begin
			return -1;
		end
		return p / CELL_UNITS;
	endfunction

	// march one ray and queue the 40 characters of its column
	function automatic void render_column(input grc_pkg::ray_t r);
		int ray_ang;
		int sx;
		int cy;
		int n;
		int ceil_row;
		int floor_row;
		longint cx;
		longint cyy;
		logic [7:0] shade;
		logic [7:0] glyph;
		grc_pkg::pix_t p;
		ray_ang = (int'(r.view_angle) + 1024 - 64 + (int'(r.column_index) * 128) / COLS) % 1024;
		sx = ray_sine(ray_ang);
		cy = ray_sine((ray_ang + 256) % 1024);

		// leaving the map counts as full range; running out of steps lands there too
		for (n = 1; n <= STEPS; n++) begin
			cx = grid_cell(int'(r.viewer_x), sx, n);
			cyy = grid_cell(int'(r.viewer_y), cy, n);
			if (cx < 0 || cx >= GRID || cyy < 0 || cyy >= GRID) begin
				n = STEPS;
				break;
			end
			if (wall_map[int'(cyy) / 4][(int'(cyy) % 4) * 16 + int'(cx)]) begin
				break;
			end
		end
		if (n > STEPS) begin
			n = STEPS;
		end

		// ceiling truncates toward zero, clamped to -1 .. half screen
		ceil_row = (ROWS * (3 * n - 40)) / (6 * n);
		if (ceil_row < -1) begin
			ceil_row = -1;
		end
		if (ceil_row > ROWS / 2) begin
			ceil_row = ROWS / 2;
		end
		floor_row = ROWS - ceil_row;

		if (8 * n <= STEPS) begin
			shade = GLYPH_HASH;
		end else if (6 * n < STEPS) begin
			shade = GLYPH_BAR;
		end else if (4 * n < STEPS) begin
			shade = GLYPH_EQUALS;
		end else if (2 * n < STEPS) begin
			shade = GLYPH_TICK;
		end else if (n < STEPS) begin
			shade = GLYPH_DOT;
		end else begin
			shade = GLYPH_BLANK;
		end

		for (int row = 0; row < ROWS; row++) begin
			if (row < ceil_row) begin
				glyph = GLYPH_BLANK;
			end else if (row > ceil_row && row < floor_row) begin
				glyph = shade;
			end else if (r.column_index[0] == 1'b0) begin
				glyph = GLYPH_BLANK;
			end else if (row * 10 > 8 * ROWS) begin
				glyph = GLYPH_UNDER;
			end else if (row * 10 > 6 * ROWS) begin
				glyph = GLYPH_DOT;
			end else begin
				glyph = GLYPH_BLANK;
			end
			p.out_column = r.column_index;
			p.out_row = 6'(row);
			p.char_code = glyph;
			p.wall_steps = 8'(n);
			p.last_row = (row == ROWS - 1);
			pending_pix.push_back(p);
		end
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= SHOWN_ERRORS) begin
			$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
		end
	endtask

	// each character transfer is matched against the oldest pending one
	always @(posedge clk) begin
		grc_pkg::pix_t want;
		if (arst_n && pix_valid && pix_ready) begin
			if (pending_pix.size() == 0) begin
				flag_mismatch("character with none pending, row", int'(pix.out_row), 0);
			end else begin
				want = pending_pix.pop_front();
				if (pix.out_column !== want.out_column) begin
					flag_mismatch("out_column", int'(pix.out_column), int'(want.out_column));
				end
				if (pix.out_row !== want.out_row) begin
					flag_mismatch("out_row", int'(pix.out_row), int'(want.out_row));
				end
				if (pix.char_code !== want.char_code) begin
					flag_mismatch("char_code", int'(pix.char_code), int'(want.char_code));
				end
				if (pix.wall_steps !== want.wall_steps) begin
					flag_mismatch("wall_steps", int'(pix.wall_steps), int'(want.wall_steps));
				end
				if (pix.last_row !== want.last_row) begin
					flag_mismatch("last_row", int'(pix.last_row), int'(want.last_row));
				end
			end
		end
	end

	// watchdog: cycles without any transfer on either channel or the apb port
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_count = 0;
		end else if ((ray_valid && ray_ready) || (pix_valid && pix_ready) || psel) begin
			stall_count = 0;
		end else begin
			stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// sink side: random stalls per character, or one long hold on request
	// ------------------------------------------------------------------

	initial begin : pix_sink
		int gap;
		pix_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_req > 0) begin
				gap = sink_hold_req;
				sink_hold_req = 0;
			end else begin
				gap = sink_idle ? $urandom_range(0, 10) : 0;
			end
			// ready only drops when a gap follows, so back-to-back stays high
			if (gap > 0) begin
				pix_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pix_ready <= 1'b1;
			do @(posedge clk); while (!pix_valid);
		end
	end

	// ------------------------------------------------------------------
	// source side and register access
	// ------------------------------------------------------------------

	function automatic grc_pkg::ray_t mk_ray(input int x, input int y, input int ang,
			input int col);
		grc_pkg::ray_t r;
		r.viewer_x = 12'(x);
		r.viewer_y = 12'(y);
		r.view_angle = 10'(ang);
		r.column_index = 7'(col);
		return r;
	endfunction

	function automatic grc_pkg::ray_t random_ray();
		return mk_ray($urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 1023), $urandom_range(0, 127));
	endfunction

	// offer one ray; valid stays high into the next call when no gap is drawn,
	// and the expected column is queued at the accepting edge
	task automatic send_ray(input grc_pkg::ray_t r);
		int gap;
		gap = feed_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			ray_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ray <= r;
		ray_valid <= 1'b1;
		do @(posedge clk); while (!ray_ready);
		render_column(r);
	endtask

	// drop valid at the edge of the last transfer, then wait out every column
	task automatic drain_columns();
		ray_valid <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup then access, register taken while penable and pready are high
	task automatic write_map_reg(input map_reg_e idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AW'(int'(idx) * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		wall_map[int'(idx)] = value;
	endtask

	task automatic load_map(input logic [63:0] r0, input logic [63:0] r1,
			input logic [63:0] r2, input logic [63:0] r3);
		write_map_reg(MAP_ROWS_0_3, r0);
		write_map_reg(MAP_ROWS_4_7, r1);
		write_map_reg(MAP_ROWS_8_11, r2);
		write_map_reg(MAP_ROWS_12_15, r3);
	endtask

	// random walls, roughly one cell in one_in
	function automatic logic [63:0] speckle(input int one_in);
		logic [63:0] v;
		for (int b = 0; b < 64; b++) begin
			v[b] = ($urandom_range(0, one_in - 1) == 0);
		end
		return v;
	endfunction

	// closed border around the map plus a few random pillars inside
	function automatic logic [63:0] boxed_rows(input int k);
		logic [63:0] v;
		int row;
		for (int rr = 0; rr < 4; rr++) begin
			row = 4 * k + rr;
			v[rr * 16 +: 16] = (row == 0 || row == GRID - 1) ? 16'hFFFF : 16'h8001;
		end
		return v | speckle(12);
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// map still at its reset value: every ray leaves the map or runs out of range
	task automatic test_open_field();
		feed_idle = 1'b1;
		sink_idle = 1'b1;
		send_ray(mk_ray(0, 0, 0, 0));
		send_ray(mk_ray(4095, 4095, 1023, 127));
		// 45 degrees from the corner: 16 cells of range end inside the map
		send_ray(mk_ray(0, 0, 128, 60));
		// one ray per quadrant from the centre, column 60 sits on the view axis
		for (int q = 0; q < 4; q++) begin
			send_ray(mk_ray(12'h800, 12'h800, q * 256, 60));
		end
		// columns past the right edge of the screen, then column 61 at angle 300
		send_ray(mk_ray(12'h800, 12'h800, 0, 120));
		send_ray(mk_ray(12'h123, 12'habc, 512, 127));
		send_ray(mk_ray(12'h800, 12'h800, 300, 61));
		drain_columns();
	endtask

	// every cell a wall: first step stops, a wall hit there clamps the ceiling at -1
	task automatic test_solid_map();
		load_map('1, '1, '1, '1);
		send_ray(mk_ray(12'h800, 12'h800, 0, 0));
		send_ray(mk_ray(12'h800, 12'h800, 0, 1));
		send_ray(mk_ray(0, 0, 512, 119));
		// on the far corner the first step already leaves the map
		send_ray(mk_ray(4095, 4095, 128, 60));
		drain_columns();
	endtask

	// single wall at row 8, column 15; ray along +x from varying x walks
	// through every wall shade band short of the blank one
	task automatic test_wall_distances();
		int targets [10] = '{1, 20, 21, 26, 27, 39, 40, 79, 80, 150};
		int vx;
		load_map('0, '0, 64'h8000, '0);
		for (int i = 0; i < 10; i++) begin
			vx = 3840 - (256 * targets[i]) / 10;
			if (vx < 0) begin
				vx = 0;
			end
			// even and odd columns alternate so both floor patterns show up
			send_ray(mk_ray(vx, 12'h880, 256, 60 + i % 2));
		end
		drain_columns();
	endtask

	// sink holds off for a long stretch while the source keeps offering,
	// so the block fills and drops ray_ready
	task automatic test_sink_backpressure();
		load_map(speckle(6), speckle(6), speckle(6), speckle(6));
		feed_idle = 1'b0;
		sink_idle = 1'b1;
		sink_hold_req = HOLD_CYCLES;
		repeat (12) send_ray(random_ray());
		drain_columns();
	endtask

	// source pauses mid-stream until nothing is pending, sink always ready
	task automatic test_drain_pause();
		feed_idle = 1'b1;
		sink_idle = 1'b0;
		repeat (2) begin
			repeat (5) send_ray(random_ray());
			drain_columns();
		end
	endtask

	// random rays over maps of different density, idle patterns varied per map
	task automatic test_random_maps();
		for (int style = 0; style < 5; style++) begin
			case (style)
				0: begin
					load_map(speckle(16), speckle(16), speckle(16), speckle(16));
					feed_idle = 1'b1;
					sink_idle = 1'b1;
				end
				1: begin
					load_map(speckle(4), speckle(4), speckle(4), speckle(4));
					feed_idle = 1'b0;
					sink_idle = 1'b0;
				end
				2: begin
					load_map(speckle(2), speckle(2), speckle(2), speckle(2));
					feed_idle = 1'b1;
					sink_idle = 1'b0;
				end
				3: begin
					load_map(boxed_rows(0), boxed_rows(1), boxed_rows(2), boxed_rows(3));
					feed_idle = 1'b0;
					sink_idle = 1'b1;
				end
				default: begin
					load_map({$urandom, $urandom}, {$urandom, $urandom},
						{$urandom, $urandom}, {$urandom, $urandom});
					feed_idle = 1'b1;
					sink_idle = 1'b1;
				end
			endcase
			repeat (60) send_ray(random_ray());
			drain_columns();
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		for (int i = 0; i <= 256; i++) begin
			sine_rom[i] = taylor_quarter(i);
		end
		for (int k = 0; k < 4; k++) begin
			wall_map[k] = '0;
		end
		errors = 0;
		stall_count = 0;
		feed_idle = 1'b1;
		sink_idle = 1'b1;
		sink_hold_req = 0;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		ray_valid <= 1'b0;
		ray <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_open_field();
		test_solid_map();
		test_wall_distances();
		test_sink_backpressure();
		test_drain_pause();
		test_random_maps();

		// stray characters after the last column would show up here
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_pix.size() != 0) begin
			flag_mismatch("characters never delivered", 0, pending_pix.size());
		end

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- grid_raycast_column_renderer.f -----
+incdir+hdl
hdl/grc_pkg.sv
hdl/grc_regs.sv
hdl/grc_ctrl.sv
hdl/grc_datapath.sv
hdl/grid_raycast_column_renderer.sv
hdl/grc_checker.sv
tb/grid_raycast_column_renderer_tb.sv
